FILE: hdl/maf_pkg.sv
// Package for the moving average filter: widths, depth, controller state
// type, and the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package maf_pkg;

  localparam int DEPTH        = 1024;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int SAMPLE_W     = 12;
  localparam int WIN_W        = 10;
  localparam int SUM_W        = 22;
  localparam int WINDOW_RESET = 512;
  localparam int LEAVE_W      = ((ADDR_W > WIN_W) ? ADDR_W : WIN_W) + 1;
  localparam int STEP_W       = $clog2(SUM_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic update;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } status_t;

  function automatic logic [WIN_W-1:0] hold_window(input logic [WIN_W-1:0] value);
    logic [WIN_W-1:0] w;
    w = value;
    if (w == '0) begin
      w = WIN_W'(1);
    end else if (int'(w) > DEPTH - 1) begin
      w = WIN_W'(DEPTH - 1);
    end
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/maf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module maf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/maf_datapath.sv
// Datapath of the moving average filter: window register, sample ring, running
// sum, restoring divider and output register. Uses maf_pkg and maf_ram.
`timescale 1ns / 1ps
`default_nettype none

module maf_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [maf_pkg::WIN_W-1:0]        cfg_data,
  input  wire logic [maf_pkg::SAMPLE_W-1:0]     sample,
  input  wire maf_pkg::cmd_t                    cmd,
  output maf_pkg::status_t                      status,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [maf_pkg::SAMPLE_W-1:0]     average
);

  import maf_pkg::*;

  logic [WIN_W-1:0]    window;
  logic [ADDR_W-1:0]   newest;
  logic [ADDR_W-1:0]   fill;
  logic [SUM_W-1:0]    running_sum;
  logic [SAMPLE_W-1:0] sample_reg;
  logic [SUM_W-1:0]    quot;
  logic [WIN_W-1:0]    rem;
  logic [STEP_W-1:0]   step;

  logic [ADDR_W-1:0]   pos;
  logic [LEAVE_W-1:0]  pos_e;
  logic [LEAVE_W-1:0]  win_e;
  logic [LEAVE_W-1:0]  leave_e;
  logic [ADDR_W-1:0]   leave;
  logic                leave_valid;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SUM_W-1:0]    running_sum_next;
  logic [WIN_W:0]      rem_shift;
  logic                quot_bit;
  logic [WIN_W-1:0]    rem_next;

  always_comb begin
    pos     = (newest == ADDR_W'(DEPTH - 1)) ? '0 : newest + ADDR_W'(1);
    pos_e   = LEAVE_W'(pos);
    win_e   = LEAVE_W'(window);
    leave_e = (pos_e >= win_e) ? pos_e - win_e : pos_e + LEAVE_W'(DEPTH) - win_e;
    leave   = leave_e[ADDR_W-1:0];
    leave_valid = LEAVE_W'(fill) >= win_e;
    running_sum_next = running_sum - (leave_valid ? SUM_W'(rd_data) : '0)
                       + SUM_W'(sample_reg);
  end

  always_comb begin
    rem_shift = {rem, quot[SUM_W-1]};
    quot_bit  = rem_shift >= {1'b0, window};
    rem_next  = quot_bit ? WIN_W'(rem_shift - {1'b0, window}) : rem_shift[WIN_W-1:0];
  end

  maf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (pos),
    .wdata (sample),
    .raddr (leave),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window      <= hold_window(WIN_W'(WINDOW_RESET));
      newest      <= '0;
      fill        <= '0;
      running_sum <= '0;
    end else if (cfg_write) begin
      window      <= hold_window(cfg_data);
      newest      <= '0;
      fill        <= '0;
      running_sum <= '0;
    end else if (cmd.update) begin
      newest      <= pos;
      running_sum <= running_sum_next;
      if (fill != ADDR_W'(DEPTH - 1)) begin
        fill <= fill + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_reg <= sample;
    end
    if (cmd.update) begin
      quot <= running_sum_next;
      rem  <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      quot <= {quot[SUM_W-2:0], quot_bit};
      rem  <= rem_next;
      step <= step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      average <= quot[SAMPLE_W-1:0];
    end
  end

  assign status.div_last = step == STEP_W'(SUM_W - 1);
  assign status.out_free = !out_valid || !out_stall;

  assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> leave != pos)
    else $error("leaving slot equals slot being written");

  assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> running_sum == '0 && newest == '0 && fill == '0)
    else $error("window write did not clear ring state");

  assert property (@(posedge clk) disable iff (rst)
    running_sum <= SUM_W'(32'(window) * ((1 << SAMPLE_W) - 1)))
    else $error("running sum exceeds window times full scale");

endmodule

`default_nettype wire

FILE: hdl/maf_ctrl.sv
// Controller of the moving average filter: sequences transfer, sum update,
// division and result hand-off. Uses maf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module maf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire maf_pkg::status_t  status,
  output maf_pkg::cmd_t          cmd
);

  import maf_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd.load     = 1'b0;
    cmd.update   = 1'b0;
    cmd.div_step = 1'b0;
    cmd.out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_UPDATE)
    else $error("transfer did not start an update");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE |=> state == ST_DIVIDE)
    else $error("update not followed by division");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && !status.out_free |=> state == ST_DONE)
    else $error("result dropped while output busy");

endmodule

`default_nettype wire

FILE: hdl/moving_average_filter_top.sv
// Moving average filter top level: controller plus datapath.
// Uses maf_pkg, maf_ctrl and maf_datapath.
//
// Input channel: sample with in_valid/in_stall; a transfer happens at a rising
// edge with in_valid high and in_stall low. Output channel: average with
// out_valid/out_stall, same rule. The window register is written by a one-cycle
// pulse on cfg_write with cfg_data; a write clamps the value to 1..DEPTH-1 and
// clears the fill count, running sum and position. Write only while idle.
// Each sample passes in order: the transfer edge writes it and reads the leaving
// sample from the ring RAM, then the sum update, the restoring divider at one
// quotient bit per cycle, and the load of the output register, where out_valid
// rises. A new sample is taken the cycle after the result enters the output
// register, so the block takes no new sample before the last one is through.
// A stalled result holds in the output register; the divider then waits for
// it to drain, and the input stays stalled meanwhile.
// Reset (rst, synchronous) sets the window to 512 and clears sum, position and
// fill count; the ring needs no clearing pass as the fill count gates removal.
`timescale 1ns / 1ps
`default_nettype none

module moving_average_filter_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [maf_pkg::WIN_W-1:0]    cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [maf_pkg::SAMPLE_W-1:0] sample,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [maf_pkg::SAMPLE_W-1:0] average
);

  import maf_pkg::*;

  cmd_t    cmd;
  status_t status;

  maf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  maf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .average   (average)
  );

endmodule

`default_nettype wire

FILE: bench/moving_average_filter_checker.sv
// Checker for the moving average filter: tracks the window register, the sample
// ring and the running sum, predicts each average and compares it on transfer.
// Depends on maf_pkg for widths and depth.
`timescale 1ns / 1ps

module moving_average_filter_checker
  import maf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [WIN_W-1:0]    cfg_data,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire logic [SAMPLE_W-1:0] average,
  output int                       failures,
  output int                       pending
);

  logic [SAMPLE_W-1:0] ring [DEPTH];
  logic [ADDR_W-1:0]   newest;
  logic [SUM_W-1:0]    run_sum;
  logic [WIN_W-1:0]    window;
  logic [SAMPLE_W-1:0] averages_due [$];

  initial begin
    failures = 0;
    pending  = 0;
  end

  function automatic logic [WIN_W-1:0] limit_window(input logic [WIN_W-1:0] value);
    int w;
    w = int'(value);
    if (w < 1) w = 1;
    if (w > DEPTH - 1) w = DEPTH - 1;
    return WIN_W'(w);
  endfunction

  task automatic clear_ring();
    for (int i = 0; i < DEPTH; i++) ring[i] = '0;
    newest  = '0;
    run_sum = '0;
  endtask

  // Drop the leaving sample, store the new one and divide by the window.
  function automatic logic [SAMPLE_W-1:0] next_average(input logic [SAMPLE_W-1:0] s);
    logic [ADDR_W-1:0] slot;
    logic [ADDR_W-1:0] leaving;
    slot    = newest + 1'b1;
    leaving = slot - ADDR_W'(window);
    run_sum = run_sum - SUM_W'(ring[leaving]);
    ring[slot] = s;
    run_sum = run_sum + SUM_W'(s);
    newest  = slot;
    return SAMPLE_W'(run_sum / SUM_W'(window));
  endfunction

  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] due;
    if (rst) begin
      clear_ring();
      window = limit_window(WIN_W'(WINDOW_RESET));
      averages_due.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (averages_due.size() == 0) begin
          $error("average: expected none, actual %0d", average);
          failures <= failures + 1;
        end else begin
          due = averages_due.pop_front();
          if (average !== due) begin
            $error("average: expected %0d, actual %0d", due, average);
            failures <= failures + 1;
          end
        end
      end
      if (cfg_write) begin
        window = limit_window(cfg_data);
        clear_ring();
      end
      if (in_valid && !in_stall) averages_due.push_back(next_average(sample));
      pending <= averages_due.size();
    end
  end

endmodule

FILE: bench/moving_average_filter_top_tb.sv
// Testbench top for the moving average filter: clock, reset, sample and
// window stimulus, output stalls and the final verdict.
// Depends on maf_pkg, moving_average_filter_top and moving_average_filter_checker.
`timescale 1ns / 1ps

module moving_average_filter_top_tb;
  import maf_pkg::*;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_write = 1'b0;
  logic [WIN_W-1:0]    cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] sample    = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SAMPLE_W-1:0] average;
  logic                steady    = 1'b0;

  int failures;
  int pending;
  int taken         = 0;
  int hold_left     = 0;
  bit pressure_done = 1'b0;

  always #1 clk = ~clk;

  moving_average_filter_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .average   (average)
  );

  moving_average_filter_checker avg_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .average   (average),
    .failures  (failures),
    .pending   (pending)
  );

  // Receiver: random stalls, one long hold so the block backs up its input.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) taken <= taken + 1;
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!pressure_done && taken >= 120) begin
        pressure_done <= 1'b1;
        hold_left     <= 300;
        out_stall     <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 38);
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return SAMPLE_W'($urandom_range(4095, 3900));
      default: return SAMPLE_W'($urandom_range(4095));
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int unsigned gap;
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!steady && $urandom_range(99) < 38) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(40, 5) : $urandom_range(3, 1);
      in_valid <= 1'b0;
      sample   <= SAMPLE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_window(input logic [WIN_W-1:0] w);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_data  <= '0;
  endtask

  task automatic run_window(input logic [WIN_W-1:0] w, input int count);
    set_window(w);
    repeat (count) send_sample(pick_sample());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset window, extreme and alternating samples.
    send_sample(12'h000);
    send_sample(12'hFFF);
    send_sample(12'hFFF);
    send_sample(12'h000);
    send_sample(12'h800);
    send_sample(12'h001);
    send_sample(12'hFFE);
    send_sample(12'hAAA);
    send_sample(12'h555);
    // Zero window holds to one: average follows the sample.
    set_window(10'd0);
    send_sample(12'hFFF);
    send_sample(12'h000);
    send_sample(12'hFFF);
    send_sample(12'h007);
    // Longest window.
    set_window(10'h3FF);
    repeat (4) send_sample(12'hFFF);
    send_sample(12'h000);
    // Full-scale sum over a short window.
    set_window(10'd2);
    repeat (3) send_sample(12'hFFF);

    run_window(10'd1, 30);
    run_window(10'd3, 30);
    run_window(WIN_W'($urandom_range(40, 4)), 60);
    wait_drained();
    steady <= 1'b1;
    run_window(WIN_W'($urandom_range(16, 2)), 60);
    wait_drained();
    steady <= 1'b0;
    // Long window that fills and then slides.
    run_window(WIN_W'($urandom_range(400, 200)), 540);
    run_window(WIN_W'($urandom_range(1022, 41)), 40);
    run_window(10'd0, 20);
    run_window(WIN_W'($urandom_range(8, 2)), 50);

    wait_drained();
    repeat (30) @(posedge clk);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
